>>> rtl/filename_utf8_validator_unit_defines.svh
// Assertion macros shared by the file name validator RTL.
`ifndef FILENAME_UTF8_VALIDATOR_UNIT_DEFINES_SVH
`define FILENAME_UTF8_VALIDATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check prop at every rising edge of clk, masked while rst is high.
`define FUV_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop at every rising edge of clk, reset cycles included.
`define FUV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FUV_ASSERT_RST(label, clk, rst, prop, msg)
`define FUV_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/fuv_pkg.sv
// Types, constants and helpers of the file name validator.
package fuv_pkg;

   localparam int unsigned COUNT_WIDTH = 11;
   localparam int unsigned MAXLEN_WIDTH = 10;
   localparam int unsigned CP_WIDTH = 21;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [MAXLEN_WIDTH-1:0] MAX_LENGTH_RESET = 10'd255;

   // Register index codes, taken from paddr above the byte offset
   localparam logic REG_MAX_LENGTH = 1'b0;

   // Byte codes with meaning to the name rules
   localparam logic [7:0] BYTE_CTRL_LAST = 8'h1f;
   localparam logic [7:0] BYTE_SPACE     = 8'h20;
   localparam logic [7:0] BYTE_DOT       = 8'h2e;
   localparam logic [7:0] BYTE_SLASH     = 8'h2f;
   localparam logic [7:0] BYTE_COLON     = 8'h3a;
   localparam logic [7:0] BYTE_BACKSLASH = 8'h5c;
   localparam logic [7:0] BYTE_DEL       = 8'h7f;
   localparam logic [7:0] LEAD2_LOW      = 8'hc2;
   localparam logic [7:0] LEAD2_HIGH     = 8'hdf;
   localparam logic [7:0] LEAD3_LOW      = 8'he0;
   localparam logic [7:0] LEAD3_HIGH     = 8'hef;
   localparam logic [7:0] LEAD4_LOW      = 8'hf0;
   localparam logic [7:0] LEAD4_HIGH     = 8'hf4;

   localparam logic [1:0] CLASS_NONE  = 2'd0;
   localparam logic [1:0] CLASS_TWO   = 2'd1;
   localparam logic [1:0] CLASS_THREE = 2'd2;
   localparam logic [1:0] CLASS_FOUR  = 2'd3;

   localparam logic [CP_WIDTH-1:0] CP_MAX        = 21'h10ffff;
   localparam logic [CP_WIDTH-1:0] CP_SURR_LOW   = 21'h00d800;
   localparam logic [CP_WIDTH-1:0] CP_SURR_HIGH  = 21'h00dfff;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       last_byte;
      logic       empty_name;
   } item_type;

   typedef struct packed {
      logic done;        // item closes a name
      logic name_valid;
   } verdict_type;

   // Smallest code point that a sequence of this class may encode
   function automatic logic [CP_WIDTH-1:0] class_minimum(input logic [1:0] cls);
      logic [CP_WIDTH-1:0] result;
      case (cls)
         CLASS_TWO:   result = 21'h000080;
         CLASS_THREE: result = 21'h000800;
         default:     result = 21'h010000;
      endcase
      return result;
   endfunction

endpackage

>>> rtl/fuv_csr.sv
// Configuration register block of the file name validator.
module fuv_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fuv_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [fuv_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [fuv_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output logic [fuv_pkg::MAXLEN_WIDTH-1:0]     max_length
);
   import fuv_pkg::*;

   logic [MAXLEN_WIDTH-1:0] max_length_ff;
   logic [MAXLEN_WIDTH-1:0] max_length_in;
   logic                    reg_index;
   logic                    write_en;

   assign reg_index = csr_paddr[CSR_ADDR_WIDTH-1];
   assign write_en  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      max_length_in = max_length_ff;
      if (write_en && reg_index == REG_MAX_LENGTH) begin
         max_length_in = csr_pwdata[MAXLEN_WIDTH-1:0];
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MAX_LENGTH: csr_prdata = {{(CSR_DATA_WIDTH-MAXLEN_WIDTH){1'b0}}, max_length_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   assign csr_pready = 1'b1;
   assign max_length = max_length_ff;

endmodule

>>> rtl/fuv_checker.sv
// Per-name running state: UTF-8 decode, byte rules, length count, verdict.
`include "filename_utf8_validator_unit_defines.svh"

module fuv_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  fuv_pkg::item_type                item,
   input  logic [fuv_pkg::MAXLEN_WIDTH-1:0] max_length,
   output fuv_pkg::verdict_type             verdict
);
   import fuv_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             pending_ff, pending_in;
   logic [CP_WIDTH-1:0]    partial_ff, partial_in;
   logic [1:0]             class_ff, class_in;
   logic                   error_ff, error_in;
   logic [7:0]             b;
   logic                   bad_char;
   logic                   cp_bad;
   logic [CP_WIDTH-1:0]    cp_next;

   assign b = item.name_byte;
   assign bad_char = (b <= BYTE_CTRL_LAST) || (b == BYTE_DEL) || (b == BYTE_SLASH)
                  || (b == BYTE_BACKSLASH) || (b == BYTE_COLON);
   assign cp_next = {partial_ff[CP_WIDTH-7:0], b[5:0]};
   assign cp_bad  = (cp_next < class_minimum(class_ff)) || (cp_next > CP_MAX)
                 || ((cp_next >= CP_SURR_LOW) && (cp_next <= CP_SURR_HIGH));

   always_comb begin
      count_in   = count_ff;
      pending_in = pending_ff;
      partial_in = partial_ff;
      class_in   = class_ff;
      error_in   = error_ff;
      verdict.done       = item.empty_name || item.last_byte;
      verdict.name_valid = 1'b0;

      if (item.empty_name) begin
         count_in   = '0;
         pending_in = '0;
         partial_in = '0;
         class_in   = CLASS_NONE;
         error_in   = 1'b0;
      end else begin
         if (count_ff == '0 && b == BYTE_SPACE) begin
            error_in = 1'b1;
         end
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         if (bad_char) begin
            error_in = 1'b1;
         end

         if (pending_ff != 2'd0) begin
            if (b[7:6] != 2'b10) begin
               // broken sequence: restart decoding at the next byte
               error_in   = 1'b1;
               pending_in = '0;
               partial_in = '0;
               class_in   = CLASS_NONE;
            end else begin
               partial_in = cp_next;
               pending_in = pending_ff - 2'd1;
               if (pending_ff == 2'd1) begin
                  if (cp_bad) begin
                     error_in = 1'b1;
                  end
                  partial_in = '0;
                  class_in   = CLASS_NONE;
               end
            end
         end else if (b[7]) begin
            if (b >= LEAD2_LOW && b <= LEAD2_HIGH) begin
               partial_in = {{(CP_WIDTH-5){1'b0}}, b[4:0]};
               pending_in = 2'd1;
               class_in   = CLASS_TWO;
            end else if (b >= LEAD3_LOW && b <= LEAD3_HIGH) begin
               partial_in = {{(CP_WIDTH-4){1'b0}}, b[3:0]};
               pending_in = 2'd2;
               class_in   = CLASS_THREE;
            end else if (b >= LEAD4_LOW && b <= LEAD4_HIGH) begin
               partial_in = {{(CP_WIDTH-3){1'b0}}, b[2:0]};
               pending_in = 2'd3;
               class_in   = CLASS_FOUR;
            end else begin
               error_in = 1'b1;
            end
         end

         if (item.last_byte) begin
            if (b == BYTE_SPACE || b == BYTE_DOT || pending_in != 2'd0
                  || count_in > {1'b0, max_length}) begin
               error_in = 1'b1;
            end
            verdict.name_valid = !error_in;
            count_in   = '0;
            pending_in = '0;
            partial_in = '0;
            class_in   = CLASS_NONE;
            error_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pending_ff <= '0;
         partial_ff <= '0;
         class_ff   <= CLASS_NONE;
         error_ff   <= 1'b0;
      end else if (step) begin
         count_ff   <= count_in;
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         class_ff   <= class_in;
         error_ff   <= error_in;
      end
   end

   `FUV_ASSERT_RST(a_pending_within_class, clock, reset,
      (pending_ff <= class_ff), "more continuation bytes pending than the sequence holds")
   `FUV_ASSERT_RST(a_clear_after_verdict, clock, reset,
      (step && verdict.done) |=> (count_ff == '0 && pending_ff == '0 && !error_ff),
      "name state not cleared after a verdict")
   `FUV_ASSERT_RST(a_idle_class_partial, clock, reset,
      (class_ff == CLASS_NONE) |-> (partial_ff == '0),
      "code point bits held outside a sequence")

endmodule

>>> rtl/filename_utf8_validator_unit.sv
// File name validator: takes one name byte per cycle while no verdict waits on a
// busy result register, and gives one verdict per name. A request is accepted every
// cycle while the result register is free or being drained; the last byte (or an
// empty-name marker) is held in the input register, and its verdict is registered
// when it advances. fuv_checker updates its per-name state as each byte advances. A
// request that does not end a name produces no response. max_length (CSR at
// byte address 0, reset 255) is read when a name's last byte is judged and is
// to be written only while no name is in flight. No clearing pass after reset.
`include "filename_utf8_validator_unit_defines.svh"

module filename_utf8_validator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_name_byte,
   input  logic                                 req_last_byte,
   input  logic                                 req_empty_name,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_name_valid,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fuv_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [fuv_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [fuv_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import fuv_pkg::*;

   logic [MAXLEN_WIDTH-1:0] max_length;
   item_type                in_item_ff, in_item_in;
   logic                    in_valid_ff, in_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_name_valid_ff, rsp_name_valid_in;
   verdict_type             verdict;
   logic                    proceed;
   logic                    req_take;

   fuv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_length  (max_length)
   );

   fuv_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .step       (proceed),
      .item       (in_item_ff),
      .max_length (max_length),
      .verdict    (verdict)
   );

   // advance the held request unless it closes a name and the result slot is busy
   assign proceed   = in_valid_ff && (!verdict.done || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proceed;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = '{name_byte: req_name_byte, last_byte: req_last_byte,
                         empty_name: req_empty_name};
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in      = rsp_valid_ff;
      rsp_name_valid_in = rsp_name_valid_ff;
      if (proceed && verdict.done) begin
         rsp_valid_in      = 1'b1;
         rsp_name_valid_in = verdict.name_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_item_ff        <= in_item_in;
      rsp_name_valid_ff <= rsp_name_valid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_name_valid = rsp_name_valid_ff;

   `FUV_ASSERT_RST(a_stalled_item_holds, clock, reset,
      (in_valid_ff && !proceed) |=> (in_valid_ff && $stable(in_item_ff)),
      "stalled request lost or changed in the input register")
   `FUV_ASSERT_RST(a_full_take_moves, clock, reset,
      (req_take && in_valid_ff) |-> proceed,
      "request accepted over an input register that does not advance")
   `FUV_ASSERT_RST(a_result_slot_free, clock, reset,
      (proceed && verdict.done) |-> (!rsp_valid_ff || rsp_ready),
      "verdict written over a response not yet taken")

endmodule

>>> tb/filename_utf8_validator_unit_tb.sv
// Self-checking testbench for the file name validator unit.
module filename_utf8_validator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fuv_pkg::*;

   localparam int unsigned TIMEOUT_NS  = 10_000_000;
   localparam int unsigned IDLE_CYCLES = 4;
   localparam int unsigned FINAL_WAIT  = 2000;

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_MAX_LENGTH = {REG_MAX_LENGTH, 2'b00};

   localparam logic [CP_WIDTH-1:0] CP_MIN_TWO    = 21'h000080;
   localparam logic [CP_WIDTH-1:0] CP_MIN_THREE  = 21'h000800;
   localparam logic [CP_WIDTH-1:0] CP_MIN_FOUR   = 21'h010000;
   localparam logic [CP_WIDTH-1:0] CP_BMP_LAST   = 21'h00ffff;
   localparam logic [CP_WIDTH-1:0] CP_SURR_SPAN  = 21'h000800;
   localparam logic [CP_WIDTH-1:0] CP_CODE_SPACE = 21'h1fffff;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC,
      READY_SPARSE
   } ready_mode_e;

   typedef enum logic [2:0] {
      FAULT_RANDOM_BYTE,
      FAULT_FORBIDDEN,
      FAULT_OVERLONG,
      FAULT_SURROGATE,
      FAULT_TOO_HIGH,
      FAULT_TRUNCATED,
      FAULT_BAD_CONT,
      FAULT_BAD_LEAD
   } fault_e;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_name_byte = 8'h00;
   logic req_last_byte = 1'b0;
   logic req_empty_name = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_name_valid;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   // per-name decode state of the predictor
   logic [COUNT_WIDTH-1:0] seen_bytes = '0;
   logic [1:0] cont_left = 2'd0;
   logic [CP_WIDTH-1:0] cp_acc = '0;
   logic [1:0] seq_class = CLASS_NONE;
   logic name_bad = 1'b0;
   logic [MAXLEN_WIDTH-1:0] max_len = MAX_LENGTH_RESET;

   logic verdict_q[$];
   logic [7:0] name_bytes[$];
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned burst_left = 0;
   int unsigned ready_tick = 0;
   bit gaps_on = 1'b0;
   ready_mode_e ready_mode = READY_ALWAYS;

   filename_utf8_validator_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_name_byte  (req_name_byte),
      .req_last_byte  (req_last_byte),
      .req_empty_name (req_empty_name),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_name_valid (rsp_name_valid),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial forever #5 clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic clear_name_state();
      seen_bytes = '0;
      cont_left = 2'd0;
      cp_acc = '0;
      seq_class = CLASS_NONE;
      name_bad = 1'b0;
   endtask

   // Update the name state with one accepted request; queue a verdict when it ends a name.
   task automatic predict_verdict(input logic [7:0] b, input logic last, input logic empty);
      logic [CP_WIDTH-1:0] floor_cp;
      if (empty) begin
         verdict_q.push_back(1'b0);
         clear_name_state();
      end else begin
         if (seen_bytes == '0 && b == BYTE_SPACE) name_bad = 1'b1;
         if (seen_bytes != COUNT_MAX) seen_bytes = seen_bytes + 1'b1;
         if (b <= BYTE_CTRL_LAST || b == BYTE_DEL || b == BYTE_SLASH ||
             b == BYTE_BACKSLASH || b == BYTE_COLON) name_bad = 1'b1;
         if (cont_left != 2'd0) begin
            if (b[7:6] != 2'b10) begin
               // drop the broken sequence and restart decoding at the next byte
               name_bad = 1'b1;
               cont_left = 2'd0;
               cp_acc = '0;
               seq_class = CLASS_NONE;
            end else begin
               cp_acc = {cp_acc[CP_WIDTH-7:0], b[5:0]};
               cont_left = cont_left - 2'd1;
               if (cont_left == 2'd0) begin
                  case (seq_class)
                     CLASS_TWO:   floor_cp = CP_MIN_TWO;
                     CLASS_THREE: floor_cp = CP_MIN_THREE;
                     default:     floor_cp = CP_MIN_FOUR;
                  endcase
                  if (cp_acc < floor_cp || cp_acc > CP_MAX ||
                      (cp_acc >= CP_SURR_LOW && cp_acc <= CP_SURR_HIGH)) name_bad = 1'b1;
                  cp_acc = '0;
                  seq_class = CLASS_NONE;
               end
            end
         end else if (b[7]) begin
            if (b >= LEAD2_LOW && b <= LEAD2_HIGH) begin
               cp_acc = {16'd0, b[4:0]};
               cont_left = 2'd1;
               seq_class = CLASS_TWO;
            end else if (b >= LEAD3_LOW && b <= LEAD3_HIGH) begin
               cp_acc = {17'd0, b[3:0]};
               cont_left = 2'd2;
               seq_class = CLASS_THREE;
            end else if (b >= LEAD4_LOW && b <= LEAD4_HIGH) begin
               cp_acc = {18'd0, b[2:0]};
               cont_left = 2'd3;
               seq_class = CLASS_FOUR;
            end else begin
               name_bad = 1'b1;
            end
         end
         if (last) begin
            if (b == BYTE_SPACE || b == BYTE_DOT) name_bad = 1'b1;
            if (cont_left != 2'd0) name_bad = 1'b1;
            if (seen_bytes > {1'b0, max_len}) name_bad = 1'b1;
            verdict_q.push_back(!name_bad);
            clear_name_state();
         end
      end
   endtask

   // Receiver: own stall pattern, and check every accepted verdict against the oldest one queued.
   always @(posedge clock) begin : verdict_check
      logic want;
      ready_tick <= ready_tick + 1;
      case (ready_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_RANDOM:   rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_PERIODIC: rsp_ready <= ((ready_tick % 7) >= 3);
         default:        rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict: expected none, actual %0b",
                     $time, rsp_name_valid);
            error_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_name_valid !== want) begin
               $display("%0t: name_valid mismatch: expected %0b, actual %0b",
                        $time, want, rsp_name_valid);
               error_count++;
            end
         end
      end
   end

   task automatic send_item(input logic [7:0] b, input logic last, input logic empty);
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_name_byte <= b;
      req_last_byte <= last;
      req_empty_name <= empty;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_verdict(b, last, empty);
      bytes_sent++;
   endtask

   task automatic send_empty();
      send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 1) == 1), 1'b1);
   endtask

   // Send the buffered name; when abandoned, cut it short with an empty-name marker.
   task automatic send_name(input bit abandon);
      int unsigned stop;
      stop = abandon ? $urandom_range(1, name_bytes.size()) : name_bytes.size();
      for (int i = 0; i < stop; i++)
         send_item(name_bytes[i], !abandon && (i == stop - 1), 1'b0);
      if (abandon) send_empty();
   endtask

   // Hold requests until every queued verdict has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [MAXLEN_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] word;
      word = $urandom();
      word[MAXLEN_WIDTH-1:0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_MAX_LENGTH;
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      max_len = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_read();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_MAX_LENGTH;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[MAXLEN_WIDTH-1:0] !== max_len) begin
         $display("%0t: max_length readback mismatch: expected %0d, actual %0d",
                  $time, max_len, csr_prdata[MAXLEN_WIDTH-1:0]);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_plain_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(BYTE_SPACE, BYTE_DEL - 1));
      while (c == BYTE_SLASH || c == BYTE_COLON || c == BYTE_BACKSLASH);
      return c;
   endfunction

   function automatic logic [CP_WIDTH-1:0] pick_codepoint(input int unsigned len);
      logic [CP_WIDTH-1:0] cp;
      case (len)
         2: cp = 21'($urandom_range(CP_MIN_TWO, CP_MIN_THREE - 1));
         3: begin
            // skip the surrogate block
            cp = 21'($urandom_range(CP_MIN_THREE, CP_BMP_LAST - CP_SURR_SPAN));
            if (cp >= CP_SURR_LOW) cp = cp + CP_SURR_SPAN;
         end
         default: cp = 21'($urandom_range(CP_MIN_FOUR, CP_MAX));
      endcase
      return cp;
   endfunction

   task automatic add_encoded(input logic [CP_WIDTH-1:0] cp, input int unsigned len);
      case (len)
         2: begin
            name_bytes.push_back({3'b110, cp[10:6]});
            name_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            name_bytes.push_back({4'b1110, cp[15:12]});
            name_bytes.push_back({2'b10, cp[11:6]});
            name_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            name_bytes.push_back({5'b11110, cp[20:18]});
            name_bytes.push_back({2'b10, cp[17:12]});
            name_bytes.push_back({2'b10, cp[11:6]});
            name_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic add_letters(input int unsigned count);
      repeat (count) name_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
   endtask

   task automatic send_letters(input int unsigned count);
      name_bytes.delete();
      add_letters(count);
      send_name(1'b0);
   endtask

   task automatic add_char();
      int unsigned len;
      if ($urandom_range(0, 9) < 6) begin
         name_bytes.push_back(pick_plain_char());
      end else begin
         len = $urandom_range(2, 4);
         add_encoded(pick_codepoint(len), len);
      end
   endtask

   task automatic add_fault(input fault_e kind);
      logic [CP_WIDTH-1:0] cp;
      int unsigned len;
      int unsigned idx;
      logic [7:0] b;
      len = $urandom_range(2, 4);
      case (kind)
         FAULT_RANDOM_BYTE: name_bytes.push_back(8'($urandom_range(0, 255)));
         FAULT_FORBIDDEN: begin
            case ($urandom_range(0, 4))
               0: b = 8'($urandom_range(0, BYTE_CTRL_LAST));
               1: b = BYTE_DEL;
               2: b = BYTE_SLASH;
               3: b = BYTE_BACKSLASH;
               default: b = BYTE_COLON;
            endcase
            name_bytes.push_back(b);
         end
         FAULT_OVERLONG: begin
            case (len)
               2: cp = 21'($urandom_range(0, CP_MIN_TWO - 1));
               3: cp = 21'($urandom_range(0, CP_MIN_THREE - 1));
               default: cp = 21'($urandom_range(0, CP_MIN_FOUR - 1));
            endcase
            add_encoded(cp, len);
         end
         FAULT_SURROGATE: add_encoded(21'($urandom_range(CP_SURR_LOW, CP_SURR_HIGH)), 3);
         FAULT_TOO_HIGH: add_encoded(21'($urandom_range(CP_MAX + 1, CP_CODE_SPACE)), 4);
         FAULT_TRUNCATED: begin
            add_encoded(pick_codepoint(len), len);
            repeat ($urandom_range(1, len - 1)) name_bytes.delete(name_bytes.size() - 1);
         end
         FAULT_BAD_CONT: begin
            idx = name_bytes.size() + $urandom_range(1, len - 1);
            add_encoded(pick_codepoint(len), len);
            do
               b = 8'($urandom_range(0, 255));
            while (b[7:6] == 2'b10);
            name_bytes[idx] = b;
         end
         default: begin
            if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(8'h80, LEAD2_LOW - 1));
            else b = 8'($urandom_range(LEAD4_HIGH + 1, 8'hff));
            name_bytes.push_back(b);
         end
      endcase
   endtask

   task automatic test_csr_access();
      csr_check_read();
      csr_write('1);
      csr_check_read();
      csr_write(10'd1);
      csr_check_read();
      csr_write(10'd0);
      csr_check_read();
      csr_write(MAX_LENGTH_RESET);
      csr_check_read();
   endtask

   task automatic test_directed_names();
      ready_mode = READY_RANDOM;
      gaps_on = 1'b1;
      send_empty();
      name_bytes = '{8'h41};
      send_name(1'b0);
      name_bytes = '{BYTE_DOT};
      send_name(1'b0);
      name_bytes = '{BYTE_SPACE, 8'h41};
      send_name(1'b0);
      name_bytes = '{8'h41, BYTE_SPACE};
      send_name(1'b0);
      name_bytes = '{8'h00};
      send_name(1'b0);
      name_bytes = '{8'hff};
      send_name(1'b0);
      name_bytes = '{8'hc2, 8'h80};
      send_name(1'b0);
      // highest legal code point, then one above it
      name_bytes = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
      send_name(1'b0);
      name_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};
      send_name(1'b0);
      name_bytes = '{8'hed, 8'ha0, 8'h80};
      send_name(1'b0);
      // broken sequence, then an open sequence dropped by an empty-name marker
      name_bytes = '{8'hc3, 8'h41};
      send_name(1'b0);
      name_bytes = '{8'hc3};
      send_name(1'b1);
      wait_idle();
   endtask

   task automatic test_length_limits();
      ready_mode = READY_RANDOM;
      gaps_on = 1'b0;
      csr_write(10'd1);
      send_letters(1);
      send_letters(2);
      wait_idle();
      csr_write(10'd0);
      send_letters(1);
      send_letters(3);
      wait_idle();
      csr_write(10'd24);
      csr_check_read();
      send_letters(24);
      send_letters(25);
      wait_idle();
   endtask

   task automatic run_random_phase(input logic [MAXLEN_WIDTH-1:0] limit,
                                   input ready_mode_e mode, input bit gaps,
                                   input int unsigned quota);
      int unsigned start;
      int unsigned target;
      csr_write(limit);
      ready_mode = mode;
      gaps_on = gaps;
      start = bytes_sent;
      while (bytes_sent - start < quota) begin
         if ($urandom_range(0, 99) < 5) begin
            send_empty();
         end else begin
            name_bytes.delete();
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 9) == 0)
                  add_fault(fault_e'($urandom_range(0, int'(FAULT_BAD_LEAD))));
               else
                  add_char();
            end
            // land near the length limit now and then
            if (max_len <= 64 && $urandom_range(0, 9) == 0) begin
               target = max_len + $urandom_range(0, 2);
               target = (target > 1) ? target - 1 : 1;
               if (name_bytes.size() < target) add_letters(target - name_bytes.size());
            end
            if ($urandom_range(0, 19) == 0) name_bytes[0] = BYTE_SPACE;
            if ($urandom_range(0, 9) == 0)
               name_bytes.push_back(($urandom_range(0, 1) == 0) ? BYTE_DOT : BYTE_SPACE);
            send_name($urandom_range(0, 29) == 0);
         end
         if ($urandom_range(0, 49) == 0) wait_idle();
      end
      wait_idle();
   endtask

   task automatic test_random_names();
      run_random_phase(10'($urandom_range(1, 16)), READY_RANDOM, 1'b1, 160);
      run_random_phase('1, READY_PERIODIC, 1'b0, 150);
      run_random_phase(10'($urandom_range(1, 1023)), READY_SPARSE, 1'b1, 160);
      run_random_phase(10'($urandom_range(2, 8)), READY_ALWAYS, 1'b1, 150);
   endtask

   initial begin : main
      int unsigned guard;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_csr_access();
      test_directed_names();
      test_length_limits();
      test_random_names();
      req_valid <= 1'b0;
      guard = 0;
      while (verdict_q.size() != 0 && guard < FINAL_WAIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (IDLE_CYCLES) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $display("%0t: verdicts missing: expected %0d more, actual 0",
                  $time, verdict_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
